// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL of the motor mixer; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property prop must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition cond must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/qxmm_pkg.sv -----
`default_nettype none

package qxmm_pkg;

  localparam int unsigned CmdW    = 16;
  localparam int unsigned MotorW  = 12;
  localparam int unsigned ScaleW  = 11;
  localparam int unsigned PwmW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned FracBits = 15;
  // Width of the exact Q.15 motor sums; every sum fits with margin.
  localparam int unsigned SumW    = 30;

  localparam int CmdGain         = 500;
  localparam int IdleOthersLimit = 910;
  localparam int IdleBrLimit     = 950;
  localparam int IdleBrValue     = 900;

  localparam logic [ScaleW-1:0] ThrottleScaleRst  = ScaleW'(500);
  localparam logic [PwmW-1:0]   ThrottleOffsetRst = PwmW'(1500);
  localparam logic [PwmW-1:0]   PwmMinRst         = PwmW'(1000);
  localparam logic [PwmW-1:0]   PwmMaxRst         = PwmW'(2000);

  typedef enum logic [CfgIdxW-1:0] {
    RegThrottleScale  = 2'd0,
    RegThrottleOffset = 2'd1,
    RegPwmMin         = 2'd2,
    RegPwmMax         = 2'd3
  } qxmm_reg_e;

  typedef struct packed {
    logic [ScaleW-1:0] throttle_scale;
    logic [PwmW-1:0]   throttle_offset;
    logic [PwmW-1:0]   pwm_min;
    logic [PwmW-1:0]   pwm_max;
  } qxmm_cfg_t;

  typedef struct packed {
    logic signed [CmdW-1:0] thrust_cmd;
    logic signed [CmdW-1:0] roll_cmd;
    logic signed [CmdW-1:0] pitch_cmd;
    logic signed [CmdW-1:0] yaw_cmd;
  } qxmm_cmd_t;

  typedef struct packed {
    logic signed [SumW-1:0] front_right;
    logic signed [SumW-1:0] back_right;
    logic signed [SumW-1:0] back_left;
    logic signed [SumW-1:0] front_left;
  } qxmm_sum_t;

endpackage

`default_nettype wire

// ----- src/qxmm_if.sv -----
`default_nettype none

// Command channel: one item carries the four Q1.15 commands.
interface qxmm_cmd_if
  import qxmm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [CmdW-1:0] thrust_cmd;
  logic signed [CmdW-1:0] roll_cmd;
  logic signed [CmdW-1:0] pitch_cmd;
  logic signed [CmdW-1:0] yaw_cmd;

  modport source (output valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
  modport sink   (input valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

// Motor channel: one item carries the four clamped PWM values.
interface qxmm_motor_if
  import qxmm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MotorW-1:0] motor_front_right;
  logic [MotorW-1:0] motor_back_right;
  logic [MotorW-1:0] motor_back_left;
  logic [MotorW-1:0] motor_front_left;

  modport source (output valid, motor_front_right, motor_back_right, motor_back_left,
                  motor_front_left, input ready);
  modport sink   (input valid, motor_front_right, motor_back_right, motor_back_left,
                  motor_front_left, output ready);
endinterface

`default_nettype wire

// ----- src/qxmm_cfg_regs.sv -----
`default_nettype none

module qxmm_cfg_regs
  import qxmm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output qxmm_cfg_t               cfg_o
);

  qxmm_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (qxmm_reg_e'(cfg_idx_i))
        RegThrottleScale:  cfg_d.throttle_scale  = cfg_wdata_i[ScaleW-1:0];
        RegThrottleOffset: cfg_d.throttle_offset = cfg_wdata_i[PwmW-1:0];
        RegPwmMin:         cfg_d.pwm_min         = cfg_wdata_i[PwmW-1:0];
        RegPwmMax:         cfg_d.pwm_max         = cfg_wdata_i[PwmW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_scale  <= ThrottleScaleRst;
      cfg_q.throttle_offset <= ThrottleOffsetRst;
      cfg_q.pwm_min         <= PwmMinRst;
      cfg_q.pwm_max         <= PwmMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/qxmm_mix.sv -----
`default_nettype none

module qxmm_mix
  import qxmm_pkg::*;
(
  input  wire qxmm_cmd_t cmd_i,
  input  wire qxmm_cfg_t cfg_i,
  output qxmm_sum_t      sum_o
);

  logic signed [SumW-1:0] thr;
  logic signed [SumW-1:0] roll_term;
  logic signed [SumW-1:0] pitch_term;
  logic signed [SumW-1:0] yaw_term;
  logic signed [SumW-1:0] offset_q15;

  // Offset moved up to 15 fraction bits, zero extended to the sum width.
  assign offset_q15 = $signed({{(SumW-PwmW-FracBits){1'b0}}, cfg_i.throttle_offset,
                               {FracBits{1'b0}}});

  assign thr = SumW'(cmd_i.thrust_cmd)
             * $signed({{(SumW-ScaleW){1'b0}}, cfg_i.throttle_scale}) + offset_q15;

  assign roll_term  = SumW'(cmd_i.roll_cmd)  * SumW'(CmdGain);
  assign pitch_term = SumW'(cmd_i.pitch_cmd) * SumW'(CmdGain);
  assign yaw_term   = SumW'(cmd_i.yaw_cmd)   * SumW'(CmdGain);

  // X-quad sign pattern.
  assign sum_o.front_right = thr - roll_term - pitch_term + yaw_term;
  assign sum_o.back_right  = thr - roll_term + pitch_term - yaw_term;
  assign sum_o.back_left   = thr + roll_term + pitch_term + yaw_term;
  assign sum_o.front_left  = thr + roll_term - pitch_term - yaw_term;

endmodule

`default_nettype wire

// ----- src/qxmm_clamp.sv -----
`default_nettype none

module qxmm_clamp
  import qxmm_pkg::*;
(
  input  wire logic signed [SumW-1:0] sum_i,
  input  wire logic [PwmW-1:0]        pwm_min_i,
  input  wire logic [PwmW-1:0]        pwm_max_i,
  output logic [MotorW-1:0]           pwm_o
);

  logic signed [SumW-1:0] hi;
  logic signed [SumW-1:0] lo;

  assign hi = $signed({{(SumW-PwmW-FracBits){1'b0}}, pwm_max_i, {FracBits{1'b0}}});
  assign lo = $signed({{(SumW-PwmW-FracBits){1'b0}}, pwm_min_i, {FracBits{1'b0}}});

  // The upper bound wins, even when it lies below the lower bound.
  always_comb begin
    if (sum_i >= hi) begin
      pwm_o = MotorW'(pwm_max_i);
    end else if (sum_i < lo) begin
      pwm_o = MotorW'(pwm_min_i);
    end else begin
      pwm_o = sum_i[FracBits +: MotorW];
    end
  end

endmodule

`default_nettype wire

// ----- src/quad_x_motor_mixer_top.sv -----
// Quad X motor mixer.
// The cmd channel takes one item per handshake: throttle, roll, pitch and yaw
// as signed Q1.15 fractions. The motor channel returns one item per command
// item with the four clamped PWM values in the order front right, back right,
// back left, front left. Both channels move an item at a rising clock edge
// where valid and ready are both high.
// The configuration port writes scale, offset and the two clamp limits; the user
// must write it only while no item is in flight; the block does not enforce this.
// An item is registered on entry and its result is registered on exit. Valid
// on the motor channel rises once the accepted item has moved from the input
// register into the output register. One item is accepted every cycle while
// the receiver takes each result; the multiply, the four-term sums and the
// clamp sit between the two registers. When the receiver stalls, the result
// waits in the output register and the input register still takes one more
// item; after that ready drops until the receiver takes the waiting result.
// Reset empties both registers and restores the default configuration.
`default_nettype none

module quad_x_motor_mixer_top
  import qxmm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  qxmm_cmd_if.sink                cmd,
  qxmm_motor_if.source            motor
);

`include "assert_macros.svh"

  qxmm_cfg_t cfg;
  qxmm_cmd_t cmd_d, cmd_q;
  qxmm_sum_t sum;
  logic      in_valid_d, in_valid_q;
  logic      out_valid_d, out_valid_q;
  logic      out_free;
  logic      out_load;
  logic      in_load;

  logic [MotorW-1:0] fr_pwm, br_pwm, bl_pwm, fl_pwm;
  logic [MotorW-1:0] br_idle;
  logic [MotorW-1:0] fr_d, br_d, bl_d, fl_d;
  logic [MotorW-1:0] fr_q, br_q, bl_q, fl_q;

  qxmm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The output register is free when empty or when its item leaves now.
  assign out_free  = !out_valid_q || motor.ready;
  assign out_load  = in_valid_q && out_free;
  assign cmd.ready = !in_valid_q || out_free;
  assign in_load   = cmd.valid && cmd.ready;

  always_comb begin
    cmd_d      = cmd_q;
    in_valid_d = in_valid_q;
    if (cmd.ready) begin
      in_valid_d = cmd.valid;
    end
    if (in_load) begin
      cmd_d.thrust_cmd = cmd.thrust_cmd;
      cmd_d.roll_cmd   = cmd.roll_cmd;
      cmd_d.pitch_cmd  = cmd.pitch_cmd;
      cmd_d.yaw_cmd    = cmd.yaw_cmd;
    end
  end

  qxmm_mix u_mix (
    .cmd_i (cmd_q),
    .cfg_i (cfg),
    .sum_o (sum)
  );

  qxmm_clamp u_clamp_fr (
    .sum_i     (sum.front_right),
    .pwm_min_i (cfg.pwm_min),
    .pwm_max_i (cfg.pwm_max),
    .pwm_o     (fr_pwm)
  );

  qxmm_clamp u_clamp_br (
    .sum_i     (sum.back_right),
    .pwm_min_i (cfg.pwm_min),
    .pwm_max_i (cfg.pwm_max),
    .pwm_o     (br_pwm)
  );

  qxmm_clamp u_clamp_bl (
    .sum_i     (sum.back_left),
    .pwm_min_i (cfg.pwm_min),
    .pwm_max_i (cfg.pwm_max),
    .pwm_o     (bl_pwm)
  );

  qxmm_clamp u_clamp_fl (
    .sum_i     (sum.front_left),
    .pwm_min_i (cfg.pwm_min),
    .pwm_max_i (cfg.pwm_max),
    .pwm_o     (fl_pwm)
  );

  // Idle rule: with the other three motors near idle, the back right motor is
  // pinned to its idle value as long as it is itself below its own limit.
  always_comb begin
    br_idle = br_pwm;
    if (fr_pwm < MotorW'(IdleOthersLimit) && bl_pwm < MotorW'(IdleOthersLimit) &&
        fl_pwm < MotorW'(IdleOthersLimit) && br_pwm < MotorW'(IdleBrLimit)) begin
      br_idle = MotorW'(IdleBrValue);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    fr_d        = fr_q;
    br_d        = br_q;
    bl_d        = bl_q;
    fl_d        = fl_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
    if (out_load) begin
      fr_d = fr_pwm;
      br_d = br_idle;
      bl_d = bl_pwm;
      fl_d = fl_pwm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    fr_q  <= fr_d;
    br_q  <= br_d;
    bl_q  <= bl_d;
    fl_q  <= fl_d;
  end

  assign motor.valid             = out_valid_q;
  assign motor.motor_front_right = fr_q;
  assign motor.motor_back_right  = br_q;
  assign motor.motor_back_left   = bl_q;
  assign motor.motor_front_left  = fl_q;

  `ASSERT_CLK(a_idle_rule, clk_i, rst_ni,
    (out_valid_q && fr_q < MotorW'(IdleOthersLimit) && bl_q < MotorW'(IdleOthersLimit) &&
     fl_q < MotorW'(IdleOthersLimit)) |-> (br_q == MotorW'(IdleBrValue) ||
     br_q >= MotorW'(IdleBrLimit)), "back right motor misses the idle rule")
  `ASSERT_CLK(a_in_held, clk_i, rst_ni,
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(cmd_q)),
    "input register lost an item while the output was stalled")
  `ASSERT_NEVER(a_ready_when_empty, clk_i, rst_ni, !out_valid_q && !cmd.ready,
    "input not ready although the output register is empty")

endmodule

`default_nettype wire
